// ----- sv/sssv_pkg.sv -----
// Shared types and constants of the strided-slice view calculator.
// Used by the front, queue and back modules and by the top level; depends on nothing.
package sssv_pkg;

    localparam int unsigned OFS_W    = 48;
    localparam int unsigned SIZE_W   = 31;
    localparam int unsigned STRIDE_W = 32;
    localparam int unsigned IDX_W    = 32;
    localparam int unsigned STEP_W   = 31;
    localparam int unsigned MUL_W    = 2 * STRIDE_W;
    localparam int unsigned NORM_W   = IDX_W + 2;
    localparam int unsigned DIV_STEPS = SIZE_W;
    localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

    // One normalized dimension, as the front hands it to the back.
    typedef struct packed {
        logic [OFS_W-1:0]    base_offset;
        logic                first_dim;
        logic [STRIDE_W-1:0] dim_stride;
        logic [SIZE_W-1:0]   begin_clamped;
        logic [SIZE_W-1:0]   length;
        logic [STEP_W-1:0]   step_size;
        logic                last_dim;
    } dim_desc_t;

    // Fill status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_CALC = 3'b010,
        BK_DONE = 3'b100
    } back_state_t;

endpackage

// ----- sv/sssv_front.sv -----
// Front part: wraps and clamps begin/end, forms the length, tracks the slice start.
// Depends on sssv_pkg.
module sssv_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic                              q_full,
    output logic                              push,
    input  logic [sssv_pkg::OFS_W-1:0]        base_offset,
    input  logic [sssv_pkg::SIZE_W-1:0]       dim_size,
    input  logic [sssv_pkg::STRIDE_W-1:0]     dim_stride,
    input  logic signed [sssv_pkg::IDX_W-1:0] begin_index,
    input  logic signed [sssv_pkg::IDX_W-1:0] end_index,
    input  logic [sssv_pkg::STEP_W-1:0]       step_size,
    input  logic                              last_dim,
    output sssv_pkg::dim_desc_t               desc
);

    logic                                at_start_reg;
    logic                                at_start_next;
    logic signed [sssv_pkg::NORM_W-1:0]  size_s;
    logic signed [sssv_pkg::NORM_W-1:0]  b_w;
    logic signed [sssv_pkg::NORM_W-1:0]  e_w;
    logic signed [sssv_pkg::NORM_W-1:0]  b_c;
    logic signed [sssv_pkg::NORM_W-1:0]  e_c;
    logic signed [sssv_pkg::NORM_W-1:0]  len_s;

    assign push = in_valid && !q_full;

    always_comb begin
        size_s = {{(sssv_pkg::NORM_W - sssv_pkg::SIZE_W){1'b0}}, dim_size};
        b_w = {{(sssv_pkg::NORM_W - sssv_pkg::IDX_W){begin_index[sssv_pkg::IDX_W-1]}},
               begin_index};
        e_w = {{(sssv_pkg::NORM_W - sssv_pkg::IDX_W){end_index[sssv_pkg::IDX_W-1]}},
               end_index};
        if (begin_index[sssv_pkg::IDX_W-1]) begin
            b_w = b_w + size_s;
        end
        if (end_index[sssv_pkg::IDX_W-1]) begin
            e_w = e_w + size_s;
        end
        if (b_w[sssv_pkg::NORM_W-1]) begin
            b_c = '0;
        end else if (b_w > size_s) begin
            b_c = size_s;
        end else begin
            b_c = b_w;
        end
        if (e_w < b_c) begin
            e_c = b_c;
        end else if (e_w > size_s) begin
            e_c = size_s;
        end else begin
            e_c = e_w;
        end
        // An empty range reports a begin of zero.
        if (b_c == e_c) begin
            b_c = '0;
            e_c = '0;
        end
        len_s = e_c - b_c;
    end

    always_comb begin
        desc.base_offset   = base_offset;
        desc.first_dim     = at_start_reg;
        desc.dim_stride    = dim_stride;
        desc.begin_clamped = b_c[sssv_pkg::SIZE_W-1:0];
        desc.length        = len_s[sssv_pkg::SIZE_W-1:0];
        // A zero step behaves as a step of one.
        desc.step_size     = (step_size == '0) ? sssv_pkg::STEP_W'(1) : step_size;
        desc.last_dim      = last_dim;
    end

    assign at_start_next = push ? last_dim : at_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
        end else begin
            at_start_reg <= at_start_next;
        end
    end

endmodule

// ----- sv/sssv_queue.sv -----
// Short queue of normalized dimensions between the front and the back.
// Depends on sssv_pkg.
module sssv_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  sssv_pkg::dim_desc_t      din,
    input  logic                     pop,
    output sssv_pkg::dim_desc_t      dout,
    output sssv_pkg::queue_status_t  status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    sssv_pkg::dim_desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign dout    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- sv/sssv_back.sv -----
// Back part: shared multiplier, radix-2 divider for the ceiling, offset accumulation
// and the output register. Depends on sssv_pkg.
module sssv_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sssv_pkg::dim_desc_t            desc,
    input  sssv_pkg::queue_status_t        q_status,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sssv_pkg::SIZE_W-1:0]    m_new_size,
    output logic [sssv_pkg::OFS_W-1:0]     m_new_stride,
    output logic [sssv_pkg::OFS_W-1:0]     m_offset_so_far,
    output logic                           m_overflow,
    output logic                           m_is_last
);

    localparam int unsigned PROD_W = sssv_pkg::MUL_W - 1;
    localparam int unsigned HI_W   = PROD_W - sssv_pkg::OFS_W;

    sssv_pkg::back_state_t             state_reg, state_next;
    logic [sssv_pkg::CNT_W-1:0]        cnt_reg;
    sssv_pkg::dim_desc_t               cur_reg;
    logic [sssv_pkg::SIZE_W-1:0]       rem_reg;
    logic [sssv_pkg::SIZE_W-1:0]       quo_reg;
    logic [PROD_W-1:0]                 pstride_reg;
    logic [PROD_W-1:0]                 pofs_reg;
    logic [sssv_pkg::OFS_W-1:0]        running_reg;
    logic                              m_valid_reg;
    logic [sssv_pkg::SIZE_W-1:0]       size_reg;
    logic [sssv_pkg::OFS_W-1:0]        stride_reg;
    logic [sssv_pkg::OFS_W-1:0]        ofs_reg;
    logic                              ovf_reg;
    logic                              last_reg;

    logic [sssv_pkg::STRIDE_W-1:0]     mul_b;
    logic [sssv_pkg::MUL_W-1:0]        mul_full;
    logic [sssv_pkg::SIZE_W:0]         trial;
    logic                              trial_ge;
    logic [sssv_pkg::SIZE_W:0]         trial_sub;
    logic [sssv_pkg::OFS_W-1:0]        acc_in;
    logic [sssv_pkg::OFS_W:0]          acc_sum;
    logic                              out_free;
    logic                              finish;

    // The multiplier forms stride * step in the first cycle and begin * stride next.
    assign mul_b = (cnt_reg == '0) ? {1'b0, cur_reg.step_size}
                                   : {1'b0, cur_reg.begin_clamped};
    assign mul_full = {{sssv_pkg::STRIDE_W{1'b0}}, cur_reg.dim_stride}
                    * {{sssv_pkg::STRIDE_W{1'b0}}, mul_b};

    assign trial     = {rem_reg, quo_reg[sssv_pkg::SIZE_W-1]};
    assign trial_ge  = (trial >= {1'b0, cur_reg.step_size});
    assign trial_sub = trial - {1'b0, cur_reg.step_size};

    assign acc_in   = cur_reg.first_dim ? cur_reg.base_offset : running_reg;
    assign acc_sum  = {1'b0, acc_in} + {1'b0, pofs_reg[sssv_pkg::OFS_W-1:0]};
    assign out_free = !m_valid_reg || m_ready;
    assign pop      = (state_reg == sssv_pkg::BK_IDLE) && !q_status.empty;
    assign finish   = (state_reg == sssv_pkg::BK_DONE) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sssv_pkg::BK_IDLE: begin
                if (!q_status.empty) begin
                    state_next = sssv_pkg::BK_CALC;
                end
            end
            sssv_pkg::BK_CALC: begin
                if (cnt_reg == sssv_pkg::CNT_W'(sssv_pkg::DIV_STEPS - 1)) begin
                    state_next = sssv_pkg::BK_DONE;
                end
            end
            sssv_pkg::BK_DONE: begin
                if (out_free) begin
                    state_next = sssv_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = sssv_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sssv_pkg::BK_IDLE;
            cnt_reg     <= '0;
            running_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == sssv_pkg::BK_CALC) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
            if (finish) begin
                running_reg <= cur_reg.last_dim ? '0 : acc_sum[sssv_pkg::OFS_W-1:0];
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= desc;
            rem_reg <= '0;
            quo_reg <= desc.length;
        end
        if (state_reg == sssv_pkg::BK_CALC) begin
            rem_reg <= trial_ge ? trial_sub[sssv_pkg::SIZE_W-1:0]
                                : trial[sssv_pkg::SIZE_W-1:0];
            quo_reg <= {quo_reg[sssv_pkg::SIZE_W-2:0], trial_ge};
            if (cnt_reg == '0) begin
                pstride_reg <= mul_full[PROD_W-1:0];
            end
            if (cnt_reg == sssv_pkg::CNT_W'(1)) begin
                pofs_reg <= mul_full[PROD_W-1:0];
            end
        end
        if (finish) begin
            // A nonzero remainder rounds the quotient up.
            size_reg   <= quo_reg + sssv_pkg::SIZE_W'(rem_reg != '0);
            stride_reg <= pstride_reg[sssv_pkg::OFS_W-1:0];
            ofs_reg    <= acc_sum[sssv_pkg::OFS_W-1:0];
            ovf_reg    <= (pstride_reg[PROD_W-1 -: HI_W] != '0)
                       || (pofs_reg[PROD_W-1 -: HI_W] != '0)
                       || acc_sum[sssv_pkg::OFS_W];
            last_reg   <= cur_reg.last_dim;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_new_size      = size_reg;
    assign m_new_stride    = stride_reg;
    assign m_offset_so_far = ofs_reg;
    assign m_overflow      = ovf_reg;
    assign m_is_last       = last_reg;

endmodule

// ----- sv/strided_slice_view_calc_core.sv -----
// Top level of the strided-slice view calculator: front, queue and back.
// Depends on sssv_pkg, sssv_front, sssv_queue and sssv_back.
//
// Usage: each input item on the s_ channel carries one dimension of a source view:
// extent, stride, begin, end, step and a flag for the last dimension of the slice.
// The base offset is taken on the first dimension of a slice and ignored after.
// Each item yields exactly one result item on the m_ channel, in order: the new
// extent, the new stride, the running storage offset and an overflow flag for this
// dimension. When m_is_last is high, m_offset_so_far is the final offset.
//
// Timing: the back runs a radix-2 divider for the ceiling of length over step, one
// quotient bit per cycle, so one item occupies the back for its load, 31 divider
// steps and the finish. With an idle back, a taken item passes through the queue,
// is loaded into the back and divided, and m_valid rises as its result is written
// to the output register. The back takes no new item before it is through with the
// last. The two products share one multiplier during the first two divider steps.
//
// Reset clears the queue, the running offset and the output valid, and marks the
// next item as the first dimension of a slice. When the receiver stalls, the result
// holds in the output register, the back waits, and the front keeps taking items
// until the queue of QUEUE_DEPTH entries is full; s_ready then drops.
module strided_slice_view_calc_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sssv_pkg::OFS_W-1:0]        s_base_offset,
    input  logic [sssv_pkg::SIZE_W-1:0]       s_dim_size,
    input  logic [sssv_pkg::STRIDE_W-1:0]     s_dim_stride,
    input  logic signed [sssv_pkg::IDX_W-1:0] s_begin_index,
    input  logic signed [sssv_pkg::IDX_W-1:0] s_end_index,
    input  logic [sssv_pkg::STEP_W-1:0]       s_step_size,
    input  logic                              s_last_dim,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sssv_pkg::SIZE_W-1:0]       m_new_size,
    output logic [sssv_pkg::OFS_W-1:0]        m_new_stride,
    output logic [sssv_pkg::OFS_W-1:0]        m_offset_so_far,
    output logic                              m_overflow,
    output logic                              m_is_last
);

    sssv_pkg::dim_desc_t     front_desc;
    sssv_pkg::dim_desc_t     back_desc;
    sssv_pkg::queue_status_t q_status;
    logic                    q_push;
    logic                    q_pop;

    // An item is taken whenever the queue has room.
    assign s_ready = !q_status.full;

    sssv_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .q_full      (q_status.full),
        .push        (q_push),
        .base_offset (s_base_offset),
        .dim_size    (s_dim_size),
        .dim_stride  (s_dim_stride),
        .begin_index (s_begin_index),
        .end_index   (s_end_index),
        .step_size   (s_step_size),
        .last_dim    (s_last_dim),
        .desc        (front_desc)
    );

    sssv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (front_desc),
        .pop     (q_pop),
        .dout    (back_desc),
        .status  (q_status)
    );

    sssv_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .desc            (back_desc),
        .q_status        (q_status),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_size      (m_new_size),
        .m_new_stride    (m_new_stride),
        .m_offset_so_far (m_offset_so_far),
        .m_overflow      (m_overflow),
        .m_is_last       (m_is_last)
    );

endmodule

// ----- sv/sssv_checker.sv -----
// Port-level checks of the strided-slice view calculator, bound to the top level.
// Depends on sssv_pkg and strided_slice_view_calc_core.
module sssv_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic [sssv_pkg::OFS_W-1:0]        s_base_offset,
    input logic [sssv_pkg::SIZE_W-1:0]       s_dim_size,
    input logic [sssv_pkg::STRIDE_W-1:0]     s_dim_stride,
    input logic signed [sssv_pkg::IDX_W-1:0] s_begin_index,
    input logic signed [sssv_pkg::IDX_W-1:0] s_end_index,
    input logic [sssv_pkg::STEP_W-1:0]       s_step_size,
    input logic                              s_last_dim,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [sssv_pkg::SIZE_W-1:0]       m_new_size,
    input logic [sssv_pkg::OFS_W-1:0]        m_new_stride,
    input logic [sssv_pkg::OFS_W-1:0]        m_offset_so_far,
    input logic                              m_overflow,
    input logic                              m_is_last
);

    // After reset the queue is empty, so the block takes an item at once.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("s_ready low right after reset");

    // A result cannot follow reset as closely as this property checks: the divider alone takes longer.
    a_no_early_result: assert property (@(posedge aclk)
        !aresetn |-> ##2 !m_valid)
        else $error("result shown too soon after reset");

    // A stalled result holds its value.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_size) && $stable(m_new_stride)
            && $stable(m_offset_so_far) && $stable(m_overflow) && $stable(m_is_last))
        else $error("stalled result changed");

    // A stalled input item holds its value.
    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_base_offset) && $stable(s_dim_size)
            && $stable(s_dim_stride) && $stable(s_begin_index) && $stable(s_end_index)
            && $stable(s_step_size) && $stable(s_last_dim))
        else $error("stalled input item changed");

endmodule

bind strided_slice_view_calc_core sssv_checker u_sssv_checker (.*);

// ----- dv/tb_strided_slice_view_calc_core.sv -----
// Self-checking testbench for strided_slice_view_calc_core: directed edge cases,
// random slices and a long output stall, checked against an in-bench predictor.
// Depends on sssv_pkg and the RTL of the calculator; reads no files.
module tb_strided_slice_view_calc_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned OFS_W    = sssv_pkg::OFS_W;
    localparam int unsigned SIZE_W   = sssv_pkg::SIZE_W;
    localparam int unsigned STRIDE_W = sssv_pkg::STRIDE_W;
    localparam int unsigned IDX_W    = sssv_pkg::IDX_W;
    localparam int unsigned STEP_W   = sssv_pkg::STEP_W;

    // One source dimension as offered on the s_ channel.
    typedef struct packed {
        logic [OFS_W-1:0]    base_offset;
        logic [SIZE_W-1:0]   dim_size;
        logic [STRIDE_W-1:0] dim_stride;
        logic [IDX_W-1:0]    begin_index;
        logic [IDX_W-1:0]    end_index;
        logic [STEP_W-1:0]   step_size;
        logic                last_dim;
    } dim_item_t;

    // One dimension of the sliced view as returned on the m_ channel.
    typedef struct packed {
        logic [SIZE_W-1:0] new_size;
        logic [OFS_W-1:0]  new_stride;
        logic [OFS_W-1:0]  offset_so_far;
        logic              overflow;
        logic              is_last;
    } view_dim_t;

    localparam logic [63:0] LIMIT48 = 64'hFFFF_FFFF_FFFF;
    localparam int          HOLD_CYCLES = 600;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [OFS_W-1:0]    s_base_offset = '0;
    logic [SIZE_W-1:0]   s_dim_size = '0;
    logic [STRIDE_W-1:0] s_dim_stride = '0;
    logic [IDX_W-1:0]    s_begin_index = '0;
    logic [IDX_W-1:0]    s_end_index = '0;
    logic [STEP_W-1:0]   s_step_size = '0;
    logic                s_last_dim = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [SIZE_W-1:0]   m_new_size;
    logic [OFS_W-1:0]    m_new_stride;
    logic [OFS_W-1:0]    m_offset_so_far;
    logic                m_overflow;
    logic                m_is_last;

    // Predictor state: the offset carried between dimensions of one slice and the
    // flag that says the next item opens a new slice.
    logic [OFS_W-1:0] carried_offset = '0;
    logic             next_opens_slice = 1'b1;

    // Expected view dimensions, oldest first, in the order the items were taken.
    view_dim_t pending_views[$];

    // Handshake pacing shared by the sender and the receiver.
    bit quiet_run = 1'b0;
    bit hold_request = 1'b0;

    int errors = 0;
    int dims_checked = 0;
    int slices_closed = 0;
    int overflows_seen = 0;
    int empty_ranges = 0;
    int input_stall_cycles = 0;

    strided_slice_view_calc_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_base_offset   (s_base_offset),
        .s_dim_size      (s_dim_size),
        .s_dim_stride    (s_dim_stride),
        .s_begin_index   (s_begin_index),
        .s_end_index     (s_end_index),
        .s_step_size     (s_step_size),
        .s_last_dim      (s_last_dim),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_size      (m_new_size),
        .m_new_stride    (m_new_stride),
        .m_offset_so_far (m_offset_so_far),
        .m_overflow      (m_overflow),
        .m_is_last       (m_is_last)
    );

    always #2 aclk = ~aclk;

    // Works out the view dimension for one accepted item and advances the slice
    // state. Begin and end are widened to 64 bits so that wrapping by the extent
    // and clamping never lose a sign; products are formed at 64 bits and the
    // overflow flag is raised when a product or the sum leaves the 48-bit range.
    function automatic view_dim_t predict_view_dim(input dim_item_t it);
        longint      extent;
        longint      lo;
        longint      hi;
        logic [63:0] divisor;
        logic [63:0] span;
        logic [63:0] stride_prod;
        logic [63:0] begin_prod;
        logic [63:0] acc;
        view_dim_t   res;
        extent = longint'(it.dim_size);
        lo = longint'($signed(it.begin_index));
        hi = longint'($signed(it.end_index));
        // A zero step behaves as a unit step.
        divisor = (it.step_size == '0) ? 64'd1 : 64'(it.step_size);

        // Negative bounds count from the end, then both land inside [0, extent]
        // with the end never below the begin.
        if (lo < 0) lo += extent;
        if (hi < 0) hi += extent;
        if (lo < 0) begin
            lo = 0;
        end else if (lo > extent) begin
            lo = extent;
        end
        if (hi < lo) begin
            hi = lo;
        end else if (hi > extent) begin
            hi = extent;
        end
        // An empty range always collapses to the origin, so it adds no offset.
        if (lo == hi) begin
            lo = 0;
            hi = 0;
            empty_ranges++;
        end

        span = 64'(hi - lo);
        res.new_size = (span == 0) ? '0 : SIZE_W'((span + divisor - 1) / divisor);

        stride_prod = 64'(it.dim_stride) * divisor;
        begin_prod = 64'(lo) * 64'(it.dim_stride);
        acc = (next_opens_slice ? 64'(it.base_offset) : 64'(carried_offset)) + begin_prod;

        res.new_stride = stride_prod[OFS_W-1:0];
        res.offset_so_far = acc[OFS_W-1:0];
        res.overflow = (stride_prod > LIMIT48) || (begin_prod > LIMIT48) || (acc > LIMIT48);
        res.is_last = it.last_dim;

        // The flag is not sticky: later dimensions carry on from the wrapped offset.
        if (it.last_dim) begin
            carried_offset = '0;
            next_opens_slice = 1'b1;
        end else begin
            carried_offset = acc[OFS_W-1:0];
            next_opens_slice = 1'b0;
        end
        return res;
    endfunction

    // Offers one item, possibly after a short or long gap, and records its
    // expected view once the handshake completes. Entered and left at a falling
    // edge; valid stays high on return so that a back-to-back item follows
    // without a bubble.
    task automatic send_dim(input dim_item_t it);
        int gap;
        gap = 0;
        if (!quiet_run && $urandom_range(99) < 25) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
        end
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_base_offset = it.base_offset;
        s_dim_size    = it.dim_size;
        s_dim_stride  = it.dim_stride;
        s_begin_index = it.begin_index;
        s_end_index   = it.end_index;
        s_step_size   = it.step_size;
        s_last_dim    = it.last_dim;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_views.push_back(predict_view_dim(it));
        @(negedge aclk);
    endtask

    // Closes a test: the input goes idle and every expected view must arrive.
    task automatic drain_views();
        s_valid = 1'b0;
        while (pending_views.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic dim_item_t make_dim(input logic [OFS_W-1:0] base,
                                           input logic [SIZE_W-1:0] extent,
                                           input logic [STRIDE_W-1:0] stride,
                                           input logic [IDX_W-1:0] lo,
                                           input logic [IDX_W-1:0] hi,
                                           input logic [STEP_W-1:0] step,
                                           input logic last);
        dim_item_t it;
        it.base_offset = base;
        it.dim_size    = extent;
        it.dim_stride  = stride;
        it.begin_index = lo;
        it.end_index   = hi;
        it.step_size   = step;
        it.last_dim    = last;
        return it;
    endfunction

    // A slice bound: mostly inside the extent or counted back from its end, with
    // some wild values and the signed extremes mixed in.
    function automatic logic [IDX_W-1:0] pick_bound(input logic [SIZE_W-1:0] extent);
        case ($urandom_range(9))
            0, 1, 2, 3: return IDX_W'($urandom_range(0, extent));
            4, 5:       return IDX_W'(-longint'($urandom_range(1, 32'(extent) + 1)));
            6:          return $urandom();
            7:          return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            8:          return '0;
            default:    return '1;
        endcase
    endfunction

    function automatic dim_item_t random_dim(input logic last);
        dim_item_t   it;
        logic [63:0] wide;
        int          pick;
        wide = {$urandom(), $urandom()};
        pick = $urandom_range(99);
        if (pick < 50) begin
            it.base_offset = OFS_W'($urandom_range(0, 1000));
        end else if (pick < 90) begin
            it.base_offset = wide[OFS_W-1:0];
        end else begin
            it.base_offset = '1;
        end

        // Small extents keep most slices meaningful; a few reach the top.
        pick = $urandom_range(99);
        if (pick < 70) begin
            it.dim_size = SIZE_W'($urandom_range(0, 64));
        end else if (pick < 85) begin
            it.dim_size = SIZE_W'($urandom_range(0, 4096));
        end else if (pick < 95) begin
            it.dim_size = SIZE_W'($urandom());
        end else begin
            it.dim_size = '1;
        end

        pick = $urandom_range(99);
        if (pick < 40) begin
            it.dim_stride = $urandom_range(0, 16);
        end else if (pick < 70) begin
            it.dim_stride = $urandom_range(0, 65535);
        end else if (pick < 90) begin
            it.dim_stride = $urandom();
        end else begin
            it.dim_stride = 32'd1 << $urandom_range(31);
        end

        pick = $urandom_range(99);
        if (pick < 40) begin
            it.step_size = STEP_W'(1);
        end else if (pick < 75) begin
            it.step_size = STEP_W'($urandom_range(2, 8));
        end else if (pick < 90) begin
            it.step_size = STEP_W'($urandom_range(1, 1000));
        end else if (pick < 98) begin
            it.step_size = STEP_W'($urandom());
        end else begin
            it.step_size = '0;
        end

        it.begin_index = pick_bound(it.dim_size);
        it.end_index = pick_bound(it.dim_size);
        it.last_dim = last;
        return it;
    endfunction

    // An item with every field drawn at random over its full width.
    function automatic dim_item_t noise_dim();
        dim_item_t   it;
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        it.base_offset = wide[OFS_W-1:0];
        it.dim_size    = SIZE_W'($urandom());
        it.dim_stride  = $urandom();
        it.begin_index = $urandom();
        it.end_index   = $urandom();
        it.step_size   = STEP_W'($urandom());
        it.last_dim    = $urandom_range(1);
        return it;
    endfunction

    // Field extremes and each boundary case of the bound normalization, built as
    // short slices so that base offset handling and slice restart are exercised.
    task automatic test_directed_edges();
        // Base offset taken on the first dimension only; the second one's base
        // must be ignored.
        send_dim(make_dim('1 - 48'd20, 31'd10, 32'd1, 32'd0, 32'd10, 31'd1, 1'b0));
        send_dim(make_dim(48'd5, 31'd10, 32'd3, 32'd2, 32'd9, 31'd3, 1'b1));
        // Negative bounds counted from the end.
        send_dim(make_dim(48'd100, 31'd10, 32'd7, -32'sd3, -32'sd1, 31'd1, 1'b0));
        // Both bounds still negative after wrapping: the range becomes empty.
        send_dim(make_dim('0, 31'd10, 32'd5, -32'sd100, -32'sd50, 31'd2, 1'b0));
        // End below begin is raised to begin, giving an empty range.
        send_dim(make_dim('0, 31'd10, 32'd5, 32'd7, 32'd3, 31'd1, 1'b0));
        // Begin beyond the extent clamps to it.
        send_dim(make_dim('0, 31'd10, 32'd5, 32'd20, 32'd30, 31'd1, 1'b1));
        // Zero step acts as a unit step.
        send_dim(make_dim(48'd1, 31'd9, 32'd4, 32'd1, 32'd8, 31'd0, 1'b1));
        // Largest step, zero extent, then the full extent with a unit step.
        send_dim(make_dim('0, 31'd1000, 32'd2, 32'd0, 32'd1000, '1, 1'b0));
        send_dim(make_dim('0, 31'd0, '1, 32'd0, 32'd5, 31'd1, 1'b0));
        send_dim(make_dim('0, '1, 32'd1, 32'd0, 32'h7FFF_FFFF, 31'd1, 1'b1));
        // Stride times step leaves 48 bits.
        send_dim(make_dim('0, 31'd4, '1, 32'd0, 32'd4, '1, 1'b1));
        // Begin times stride leaves 48 bits, then the next dimension carries on
        // from the wrapped offset without the flag.
        send_dim(make_dim('0, '1, '1, 32'h7000_0000, -32'sd1, 31'd2, 1'b0));
        send_dim(make_dim('1, 31'd8, 32'd2, 32'd1, 32'd3, 31'd1, 1'b1));
        // The running sum alone leaves 48 bits.
        send_dim(make_dim('1, 31'd4, 32'd1, 32'd1, 32'd4, 31'd1, 1'b1));
        // Signed extremes of both bounds.
        send_dim(make_dim('0, '1, 32'd3, 32'h8000_0000, 32'h8000_0000, 31'd1, 1'b0));
        send_dim(make_dim('0, '1, 32'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1, 1'b0));
        send_dim(make_dim('0, '1, 32'd3, 32'h8000_0000, 32'h7FFF_FFFF, 31'd5, 1'b1));
        // All-zero and all-one items.
        send_dim(make_dim('0, '0, '0, '0, '0, '0, 1'b1));
        send_dim(make_dim('1, '1, '1, '1, '1, '1, 1'b1));
        drain_views();
    endtask

    // Well-formed slices of rank one to six with random content, plus, at about one
    // pick in ten, a single item of pure noise with a random last flag.
    task automatic test_random_slices(input int item_goal, input bit no_gaps);
        int sent;
        int rank;
        sent = 0;
        quiet_run = no_gaps;
        while (sent < item_goal) begin
            if ($urandom_range(9) == 0) begin
                send_dim(noise_dim());
                sent++;
            end else begin
                rank = $urandom_range(1, 6);
                for (int d = 0; d < rank; d++) begin
                    send_dim(random_dim(d == rank - 1));
                    sent++;
                end
            end
        end
        drain_views();
        quiet_run = 1'b0;
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // queue fills and the input stalls; everything must then drain in order.
    task automatic test_result_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_dim(random_dim(($urandom_range(3) == 0) || (i == 29)));
        end
        drain_views();
    endtask

    // Receiver: drives m_ready at the falling edge and checks each accepted view
    // at the rising edge against the oldest expectation. The long hold-off is
    // counted here, cycle by cycle.
    initial begin : result_side
        int        hold_left;
        view_dim_t seen;
        view_dim_t want;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else if (quiet_run) begin
                m_ready = 1'b1;
            end else begin
                m_ready = ($urandom_range(99) >= 25);
            end

            @(posedge aclk);
            if (aresetn && s_valid && !s_ready) input_stall_cycles++;
            if (aresetn && m_valid && m_ready) begin
                seen = '{m_new_size, m_new_stride, m_offset_so_far, m_overflow, m_is_last};
                if (pending_views.size() == 0) begin
                    $error("view dimension returned with none expected");
                    errors++;
                end else begin
                    want = pending_views.pop_front();
                    if (seen.new_size !== want.new_size) begin
                        $error("new_size: expected %0d, actual %0d",
                               want.new_size, seen.new_size);
                        errors++;
                    end
                    if (seen.new_stride !== want.new_stride) begin
                        $error("new_stride: expected 0x%012h, actual 0x%012h",
                               want.new_stride, seen.new_stride);
                        errors++;
                    end
                    if (seen.offset_so_far !== want.offset_so_far) begin
                        $error("offset_so_far: expected 0x%012h, actual 0x%012h",
                               want.offset_so_far, seen.offset_so_far);
                        errors++;
                    end
                    if (seen.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, seen.overflow);
                        errors++;
                    end
                    if (seen.is_last !== want.is_last) begin
                        $error("is_last: expected %0b, actual %0b",
                               want.is_last, seen.is_last);
                        errors++;
                    end
                end
                dims_checked++;
                if (m_overflow) overflows_seen++;
                if (m_is_last) slices_closed++;
            end
        end
    end

    // Main sequence: reset once, then each test in turn, then a quiet tail long
    // enough for a stray result to show up after the last expected one.
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_edges();
        test_random_slices(150, 1'b1);
        test_result_backpressure();
        test_random_slices(950, 1'b0);

        repeat (60) @(posedge aclk);
        $display("Covered %0d dimensions in %0d closed slices: %0d overflowed, %0d empty ranges.",
                 dims_checked, slices_closed, overflows_seen, empty_ranges);
        $display("Input was held back for %0d cycles by a full block.", input_stall_cycles);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about 1200 items, each through the
    // full divider, plus every gap and stall.
    initial begin
        #4ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
